// ----- sv/piat_pkg.sv -----
// ----------------------------------------------------------------------------
// piat_pkg
// Shared types and constants of the invoice acceptance table.
// ----------------------------------------------------------------------------
package piat_pkg;

  localparam int TableDepth = 16;
  localparam int KeyWords   = 4;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int WordW      = $clog2(KeyWords);
  localparam int MemAw      = $clog2(TableDepth * KeyWords);

  typedef logic [2:0] status_t;
  localparam status_t StOk          = 3'd0;
  localparam status_t StUnknown     = 3'd1;
  localparam status_t StExpired     = 3'd2;
  localparam status_t StAmountLow   = 3'd3;
  localparam status_t StWrongSecret = 3'd4;
  localparam status_t StPaid        = 3'd5;
  localparam status_t StLockLow     = 3'd6;
  localparam status_t StFull        = 3'd7;

  typedef logic [1:0] req_t;
  localparam req_t ReqAdd   = 2'd0;
  localparam req_t ReqCheck = 2'd1;
  localparam req_t ReqPrune = 2'd2;
  localparam req_t ReqClear = 2'd3;

  localparam logic [1:0] LastWord = 2'(KeyWords - 1);

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLatch,      // capture request fields
    OpStage,      // write a staging word
    OpAddMeta,    // write metadata of the new entry
    OpAddKey,     // write one key word of the new entry
    OpRdKey,      // issue key read of entry idx, word
    OpCmpKey,     // compare key word read data
    OpRdSec,      // issue secret read
    OpCmpSec,     // compare secret word read data
    OpPay,        // set paid flag of entry idx
    OpMoveMeta,   // copy metadata src -> dst
    OpMoveWord,   // copy one word from registered read data
    OpClear       // empty table
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  dst;
    logic [WordW-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    req_t            req;
    logic            key_eq;    // all key words compared so far equal
    logic            sec_eq;
    logic            paid;      // paid flag of entry idx
    logic            expired;   // entry idx expired at latched time
    logic            amt_low;
    logic            sec_req;   // entry idx wants a secret
    logic            has_sec;
    logic            lock_low;
  } stat_t;

endpackage

// ----- sv/piat_ram.sv -----
// ----------------------------------------------------------------------------
// piat_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module piat_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/piat_datapath.sv -----
// ----------------------------------------------------------------------------
// piat_datapath
// Entry storage, staging, request latch and comparators.
// ----------------------------------------------------------------------------
module piat_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  piat_pkg::cmd_t        cmd,
  output piat_pkg::stat_t       stat,
  input  logic [15:0]           min_final_delta,
  input  logic [1:0]            req_type,
  input  logic [1:0]            word_index,
  input  logic [63:0]           hash_word,
  input  logic [63:0]           secret_word,
  input  logic                  secret_present,
  input  logic [63:0]           amount,
  input  logic [31:0]           start_time,
  input  logic [31:0]           lifetime,
  input  logic [31:0]           lock_height,
  input  logic [31:0]           block_height,
  input  logic [31:0]           current_time,
  input  logic [piat_pkg::CntW-1:0] count_set,
  input  logic                  count_we
);
  import piat_pkg::*;

  logic [63:0] hash_staging [KeyWords];
  logic [63:0] secret_staging [KeyWords];
  logic        secret_flag [TableDepth];
  logic [63:0] amount_store [TableDepth];
  logic [31:0] start_time_store [TableDepth];
  logic [31:0] lifetime_store [TableDepth];
  logic        paid_flag [TableDepth];
  logic [CntW-1:0] entry_count;

  req_t        req;
  logic        has_sec;
  logic [63:0] amt;
  logic [31:0] st_time, life, lock, height, now;
  logic        key_eq, sec_eq;

  logic            hwe, swe;
  logic [MemAw-1:0] waddr, raddr;
  logic [63:0]     hwdata, swdata, hrdata, srdata;
  logic [31:0]     end_time, lock_min;

  // Memory addressing
  always_comb begin
    raddr  = {cmd.idx, cmd.word};
    waddr  = {cmd.idx, cmd.word};
    hwe    = 1'b0;
    swe    = 1'b0;
    hwdata = hash_staging[cmd.word];
    swdata = has_sec ? secret_staging[cmd.word] : 64'd0;
    if (cmd.op == OpAddKey) begin
      hwe = 1'b1;
      swe = 1'b1;
    end else if (cmd.op == OpMoveWord) begin
      waddr  = {cmd.dst, cmd.word};
      hwe    = 1'b1;
      swe    = 1'b1;
      hwdata = hrdata;
      swdata = srdata;
    end
  end

  piat_ram #(.Width(64), .Depth(TableDepth * KeyWords)) u_hash (
    .clk, .we(hwe), .waddr, .wdata(hwdata), .raddr, .rdata(hrdata));
  piat_ram #(.Width(64), .Depth(TableDepth * KeyWords)) u_secret (
    .clk, .we(swe), .waddr, .wdata(swdata), .raddr, .rdata(srdata));

  // Control state: entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.op == OpClear) begin
      entry_count <= '0;
    end else if (count_we) begin
      entry_count <= count_set;
    end
  end

  // Staging, latch, metadata and compare flags
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OpStage: begin
        hash_staging[word_index]   <= hash_word;
        secret_staging[word_index] <= secret_word;
      end
      OpLatch: begin
        hash_staging[LastWord]   <= hash_word;
        secret_staging[LastWord] <= secret_word;
        req     <= req_type;
        has_sec <= secret_present;
        amt     <= amount;
        st_time <= start_time;
        life    <= lifetime;
        lock    <= lock_height;
        height  <= block_height;
        now     <= current_time;
      end
      OpAddMeta: begin
        secret_flag[cmd.idx]      <= has_sec;
        amount_store[cmd.idx]     <= amt;
        start_time_store[cmd.idx] <= st_time;
        lifetime_store[cmd.idx]   <= life;
        paid_flag[cmd.idx]        <= 1'b0;
      end
      OpRdKey: if (cmd.word == '0) key_eq <= 1'b1;
      OpCmpKey: key_eq <= key_eq & (hrdata == hash_staging[cmd.word]);
      OpRdSec: if (cmd.word == '0) sec_eq <= 1'b1;
      OpCmpSec: sec_eq <= sec_eq & (srdata == secret_staging[cmd.word]);
      OpPay: paid_flag[cmd.idx] <= 1'b1;
      OpMoveMeta: begin
        secret_flag[cmd.dst]      <= secret_flag[cmd.idx];
        amount_store[cmd.dst]     <= amount_store[cmd.idx];
        start_time_store[cmd.dst] <= start_time_store[cmd.idx];
        lifetime_store[cmd.dst]   <= lifetime_store[cmd.idx];
        paid_flag[cmd.dst]        <= paid_flag[cmd.idx];
      end
      default: ;
    endcase
  end

  // Checks on the selected entry
  assign end_time = start_time_store[cmd.idx] + lifetime_store[cmd.idx];
  assign lock_min = height + {16'd0, min_final_delta};

  always_comb begin
    stat.count    = entry_count;
    stat.req      = req;
    stat.key_eq   = key_eq;
    stat.sec_eq   = sec_eq;
    stat.paid     = paid_flag[cmd.idx];
    stat.expired  = (lifetime_store[cmd.idx] != 32'd0) && (now >= end_time);
    stat.amt_low  = (amount_store[cmd.idx] != 64'd0) && (amt < amount_store[cmd.idx]);
    stat.sec_req  = secret_flag[cmd.idx];
    stat.has_sec  = has_sec;
    stat.lock_low = (height != 32'd0) && (lock < lock_min);
  end
endmodule

// ----- sv/piat_ctrl.sv -----
// ----------------------------------------------------------------------------
// piat_ctrl
// Request sequencer: add, lookup walk, prune compaction and clear.
// ----------------------------------------------------------------------------
module piat_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                word_index,
  output logic                      busy,
  output piat_pkg::cmd_t            cmd,
  input  piat_pkg::stat_t           stat,
  output logic [piat_pkg::CntW-1:0] count_set,
  output logic                      count_we,
  output logic                      done,
  output logic [2:0]                status,
  output logic [4:0]                removed_total,
  output logic [4:0]                entries_used
);
  import piat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADDKEY, S_LRD, S_LCMP, S_LNEXT, S_SRD, S_SCMP,
    S_DECIDE, S_PTEST, S_PMOVE, S_PWORD, S_DONE
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx, dst;
  logic [CntW-1:0] keep, scan, rem;
  logic [WordW-1:0] word;
  logic            wlast;
  status_t         res;

  assign busy  = (state != S_IDLE);
  assign wlast = (word == WordW'(KeyWords - 1));

  // Command decode
  always_comb begin
    cmd.op   = OpNone;
    cmd.idx  = idx;
    cmd.dst  = dst;
    cmd.word = word;
    unique case (state)
      S_IDLE:
        if (start) cmd.op = (word_index == LastWord) ? OpLatch : OpStage;
      S_ADDKEY: cmd.op = OpAddKey;
      S_LRD:    cmd.op = OpRdKey;
      S_LCMP:   cmd.op = OpCmpKey;
      S_SRD:    cmd.op = OpRdSec;
      S_SCMP:   cmd.op = OpCmpSec;
      S_PWORD:  cmd.op = OpMoveWord;
      default:  cmd.op = OpNone;
    endcase
    // metadata of a new entry goes to the slot at the current count
    if (state == S_DISPATCH && stat.req == ReqAdd && stat.count < CntW'(TableDepth)) begin
      cmd.op  = OpAddMeta;
      cmd.idx = stat.count[IdxW-1:0];
    end
    if (state == S_DISPATCH && stat.req == ReqClear) cmd.op = OpClear;
    if (state == S_DECIDE && !stat.paid && !stat.expired && !stat.amt_low &&
        !(stat.sec_req && !(stat.has_sec && stat.sec_eq)) && !stat.lock_low)
      cmd.op = OpPay;
    if (state == S_PMOVE) cmd.op = OpMoveMeta;
  end

  always_comb begin
    count_we  = 1'b0;
    count_set = stat.count + 1'b1;
    if (state == S_DISPATCH && stat.req == ReqAdd && stat.count < CntW'(TableDepth))
      count_we = 1'b1;
    if (state == S_PTEST && scan >= stat.count) begin
      count_we  = 1'b1;
      count_set = keep;
    end
  end

  // Sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE:
          if (start && word_index == LastWord) state <= S_DISPATCH;
        S_DISPATCH: begin
          word <= '0;
          res  <= StOk;
          rem  <= '0;
          unique case (stat.req)
            ReqAdd: begin
              idx <= stat.count[IdxW-1:0];
              if (stat.count >= CntW'(TableDepth)) begin
                res   <= StFull;
                state <= S_DONE;
              end else begin
                state <= S_ADDKEY;
              end
            end
            ReqCheck: begin
              idx  <= '0;
              scan <= '0;
              if (stat.count == '0) begin
                res   <= StUnknown;
                state <= S_DONE;
              end else begin
                state <= S_LRD;
              end
            end
            ReqPrune: begin
              idx   <= '0;
              scan  <= '0;
              keep  <= '0;
              state <= S_PTEST;
            end
            default: state <= S_DONE;
          endcase
        end
        S_ADDKEY: begin
          word <= word + 1'b1;
          if (wlast) state <= S_DONE;
        end
        S_LRD: state <= S_LCMP;
        S_LCMP: begin
          word <= word + 1'b1;
          state <= wlast ? S_LNEXT : S_LRD;
        end
        S_LNEXT: begin
          word <= '0;
          if (stat.key_eq) begin
            state <= S_SRD;
          end else if (scan + 1'b1 >= stat.count) begin
            res   <= StUnknown;
            state <= S_DONE;
          end else begin
            scan  <= scan + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_LRD;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          word <= word + 1'b1;
          state <= wlast ? S_DECIDE : S_SRD;
        end
        S_DECIDE: begin
          priority if (stat.paid) res <= StPaid;
          else if (stat.expired) res <= StExpired;
          else if (stat.amt_low) res <= StAmountLow;
          else if (stat.sec_req && !(stat.has_sec && stat.sec_eq)) res <= StWrongSecret;
          else if (stat.lock_low) res <= StLockLow;
          else res <= StOk;
          state <= S_DONE;
        end
        S_PTEST: begin
          word <= '0;
          if (scan >= stat.count) begin
            state <= S_DONE;
          end else if (stat.paid || stat.expired) begin
            rem  <= rem + 1'b1;
            scan <= scan + 1'b1;
            idx  <= idx + 1'b1;
          end else if (keep == scan) begin
            keep <= keep + 1'b1;
            scan <= scan + 1'b1;
            idx  <= idx + 1'b1;
          end else begin
            dst   <= keep[IdxW-1:0];
            state <= S_PMOVE;
          end
        end
        S_PMOVE: state <= S_PWORD;
        S_PWORD: begin
          // read data of word w is registered, present in the cycle after its read address;
          // address stays on idx/word, so each word passes through S_PMOVE and S_PWORD
          word <= word + 1'b1;
          if (wlast) begin
            keep  <= keep + 1'b1;
            scan  <= scan + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_PTEST;
          end else begin
            state <= S_PMOVE;
          end
        end
        S_DONE: begin
          done          <= 1'b1;
          status        <= res;
          removed_total <= 5'(rem);
          entries_used  <= 5'(stat.count);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/payment_invoice_acceptance_table_top.sv -----
// ----------------------------------------------------------------------------
// payment_invoice_acceptance_table_top
// Invoice table with add, check, prune and clear requests.
// ----------------------------------------------------------------------------
// Beats 0..2 of a key are taken while idle and leave busy low. A beat 3
// request raises busy and its result strobes on done: add writes the new
// entry (or reports full), check walks the entries key word by key word and
// then reads the secret of a matching entry, prune tests each entry and
// moves the kept ones down word by word, clear empties the table. The walk
// over the key and secret RAM uses one word per read, registered. done
// strobes one cycle per result; the receiver cannot stall it.
module payment_invoice_acceptance_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  req_type,
  input  logic [1:0]  word_index,
  input  logic [63:0] hash_word,
  input  logic [63:0] secret_word,
  input  logic        secret_present,
  input  logic [63:0] amount,
  input  logic [31:0] start_time,
  input  logic [31:0] lifetime,
  input  logic [31:0] lock_height,
  input  logic [31:0] block_height,
  input  logic [31:0] current_time,
  output logic [2:0]  status,
  output logic [4:0]  removed_total,
  output logic [4:0]  entries_used,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import piat_pkg::*;

  cmd_t            cmd;
  stat_t           stat;
  logic [CntW-1:0] count_set;
  logic            count_we;
  logic [15:0]     min_final_delta;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'd0, min_final_delta} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_final_delta <= 16'd18;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      min_final_delta <= pwdata[15:0];
    end
  end

  piat_ctrl u_ctrl (
    .clk, .rst, .start, .word_index, .busy, .cmd, .stat, .count_set, .count_we,
    .done, .status, .removed_total, .entries_used);

  piat_datapath u_dp (
    .clk, .rst, .cmd, .stat, .min_final_delta, .req_type, .word_index, .hash_word,
    .secret_word, .secret_present, .amount, .start_time, .lifetime, .lock_height,
    .block_height, .current_time, .count_set, .count_we);
endmodule
